>>> hdl/aligned_free_run_finder_core_assert.svh
// assertion macros used by the checker file
`ifndef ALIGNED_FREE_RUN_FINDER_CORE_ASSERT_SVH
`define ALIGNED_FREE_RUN_FINDER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AFRF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afrf check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define AFRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afrf check failed: next-cycle property");

`endif

>>> hdl/afrf_pkg.sv
// shared types and constants of the aligned free run finder
package afrf_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;

  localparam int PAGE_W = 12;   // page index
  localparam int CNT_W  = 13;   // page counts, run length
  localparam int CAND_W = 14;   // candidate start, may lie past the arena
  localparam int RUNS_W = 14;
  localparam int BASE_W = 40;
  localparam int ALN_W  = 6;
  localparam int WIDE_W = 52;   // alignment masks up to 2^51 - 1

  localparam logic [RUNS_W-1:0] RUNS_SAT = '1;

  // request codes
  localparam logic REQ_SET    = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_BASE_PAGE   = 1'b0;
  localparam logic [0:0] CFG_ARENA_PAGES = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] page_index;
    logic              page_free;
    logic [CNT_W-1:0]  run_length;
    logic [ALN_W-1:0]  align_exp;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] start_index;
    logic [RUNS_W-1:0] runs_examined;
  } out_item_t;

endpackage

>>> hdl/aligned_free_run_finder_core.sv
// top level of the aligned free run finder: page free map and next-fit search
//
// usage
// - input channel: a transaction is taken at a clock edge with start high and
//   busy low; in_data carries the request (set page state or search)
// - result channel: one result per transaction, shown on out_data for exactly
//   one cycle while out_valid is high; the receiver cannot stall it
// - config port: cfg_we/cfg_index/cfg_wdata write base_page (0) or
//   arena_pages (1), one per write; write only while no transaction is in flight
// - a set request: result in the cycle after acceptance, and busy
//   stays low, so set requests can follow back to back
// - a search: the prep and align setup states, then per candidate a loop
//   state visit and a walk over the pages checked through the registered read,
//   plus a realign in the align state after a busy page; each arena overrun and
//   the return of the sweep to the hint take a loop state visit; the result shows
//   in the cycle after the last of these; the walk reads the free map's one read port
//   one page a cycle; a zero run length answers from the prep state
// - after reset the free map is swept to all pages in use, one page a cycle,
//   which keeps busy high until every page is cleared; config writes are taken meanwhile
module aligned_free_run_finder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  afrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  output afrf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [afrf_pkg::BASE_W-1:0] cfg_wdata
);

  import afrf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_ALIGN,
    ST_LOOP,
    ST_WALK
  } state_t;

  localparam logic [CNT_W-1:0]  MAX_PAGES_C   = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0]  FIRST_CLAMP   = CNT_W'(MAX_PAGES + 1);
  localparam logic [ALN_W-1:0]  PAGE_SHIFT_C  = ALN_W'(PAGE_SHIFT);
  localparam logic [PAGE_W-1:0] LAST_PAGE     = PAGE_W'(MAX_PAGES - 1);

  state_t            state_r, state_nxt;
  logic [PAGE_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [BASE_W-1:0] base_r;
  logic [CNT_W-1:0]  arena_r;
  logic [PAGE_W-1:0] hint_r, hint_nxt;

  // per-search working registers
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [ALN_W-1:0]  align_r, align_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [PAGE_W-1:0] initial_r, initial_nxt;
  logic [CNT_W-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  off_r, off_nxt;
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [RUNS_W-1:0] runs_r, runs_nxt;

  // free map walk, one read in flight
  logic [PAGE_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [PAGE_W-1:0] pend_idx_r, pend_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // ram ports
  logic              ram_we;
  logic [PAGE_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_q;

  logic accept;

  // setup arithmetic
  logic [ALN_W-1:0]  a_clamped;
  logic [ALN_W-1:0]  k_shift;
  logic [WIDE_W-1:0] mask_wide;
  logic [WIDE_W-1:0] first_wide;

  // shared realign unit
  logic [CAND_W-1:0] al_diff;
  logic [CAND_W-1:0] al_sum;
  logic [CAND_W-1:0] al_result;

  // loop head
  logic              loop_go;
  logic              cand_fits;
  logic [CAND_W:0]   cand_end;
  logic [RUNS_W-1:0] runs_inc;
  logic [CNT_W-1:0]  run_end;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  afrf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PAGES)
  ) u_free_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_q)
  );

  // free map writes: clearing sweep after reset, else set requests
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = accept && (in_data.req_type == REQ_SET) &&
                  ({1'b0, in_data.page_index} < MAX_PAGES_C);
      ram_waddr = in_data.page_index;
      ram_wdata = in_data.page_free;
    end
  end

  // alignment mask and first aligned page at full width; clamped in the prep state
  always_comb begin
    a_clamped  = (align_r < PAGE_SHIFT_C) ? PAGE_SHIFT_C : align_r;
    k_shift    = a_clamped - PAGE_SHIFT_C;
    mask_wide  = (WIDE_W'(1) << k_shift) - WIDE_W'(1);
    first_wide = (WIDE_W'(0) - {{(WIDE_W-BASE_W){1'b0}}, base_r}) & mask_wide;
  end

  // round off_r up to the next aligned page at or after it
  always_comb begin
    al_diff = CAND_W'(off_r) - CAND_W'(first_r);
    al_sum  = al_diff + CAND_W'(mask_r);
    if (off_r < first_r) begin
      al_result = CAND_W'(first_r);
    end else begin
      al_result = (al_sum & ~CAND_W'(mask_r)) + CAND_W'(first_r);
    end
  end

  // loop head terms
  always_comb begin
    loop_go   = !wrapped_r || (cand_r < CAND_W'(initial_r));
    cand_end  = (CAND_W+1)'(cand_r) + (CAND_W+1)'(len_r);
    cand_fits = cand_end <= (CAND_W+1)'(n_r);
    runs_inc  = (runs_r == RUNS_SAT) ? runs_r : runs_r + RUNS_W'(1);
    run_end   = CNT_W'(cand_end);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    hint_nxt      = hint_r;
    len_nxt       = len_r;
    align_nxt     = align_r;
    n_nxt         = n_r;
    initial_nxt   = initial_r;
    mask_nxt      = mask_r;
    first_nxt     = first_r;
    off_nxt       = off_r;
    cand_nxt      = cand_r;
    wrapped_nxt   = wrapped_r;
    runs_nxt      = runs_r;
    rd_idx_nxt    = rd_idx_r;
    left_nxt      = left_r;
    pend_v_nxt    = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + PAGE_W'(1);
        if (clr_idx_r == LAST_PAGE) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_SET) begin
            // set request answers with an all-zero result
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end else begin
            len_nxt   = in_data.run_length;
            align_nxt = in_data.align_exp;
            state_nxt = ST_PREP;
          end
        end
      end

      ST_PREP: begin
        if (len_r == '0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          mask_nxt    = (|mask_wide[WIDE_W-1:CNT_W]) ? '1 : mask_wide[CNT_W-1:0];
          first_nxt   = (first_wide > WIDE_W'(MAX_PAGES)) ? FIRST_CLAMP :
                        first_wide[CNT_W-1:0];
          n_nxt       = (arena_r > MAX_PAGES_C) ? MAX_PAGES_C : arena_r;
          initial_nxt = hint_r;
          off_nxt     = CNT_W'(hint_r);
          wrapped_nxt = 1'b0;
          runs_nxt    = '0;
          state_nxt   = ST_ALIGN;
        end
      end

      ST_ALIGN: begin
        cand_nxt  = al_result;
        state_nxt = ST_LOOP;
      end

      ST_LOOP: begin
        if (!loop_go) begin
          // back at the hint after the wrap: nothing found
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b0, start_index: '0, runs_examined: runs_r};
          state_nxt     = ST_IDLE;
        end else begin
          runs_nxt = runs_inc;
          if (!cand_fits) begin
            if (wrapped_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{found: 1'b0, start_index: '0, runs_examined: runs_inc};
              state_nxt     = ST_IDLE;
            end else begin
              wrapped_nxt = 1'b1;
              cand_nxt    = CAND_W'(first_r);
            end
          end else begin
            // walk the candidate from its last page back to its first
            rd_idx_nxt = PAGE_W'(run_end - CNT_W'(1));
            left_nxt   = len_r;
            state_nxt  = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (left_r != '0) begin
          rd_idx_nxt   = rd_idx_r - PAGE_W'(1);
          left_nxt     = left_r - CNT_W'(1);
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = rd_idx_r;
        end
        if (pend_v_r && !ram_q) begin
          // busy page: next candidate is the first aligned page past it
          pend_v_nxt = 1'b0;
          off_nxt    = CNT_W'(pend_idx_r) + CNT_W'(1);
          state_nxt  = ST_ALIGN;
        end else if (pend_v_r && (left_r == '0)) begin
          hint_nxt      = (run_end == n_r) ? '0 : PAGE_W'(run_end);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{found: 1'b1, start_index: PAGE_W'(cand_r),
                            runs_examined: runs_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      hint_r      <= '0;
      base_r      <= '0;
      arena_r     <= MAX_PAGES_C;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hint_r      <= hint_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_PAGE:   base_r  <= cfg_wdata;
          CFG_ARENA_PAGES: arena_r <= cfg_wdata[CNT_W-1:0];
          default:         ;
        endcase
      end
    end
    len_r      <= len_nxt;
    align_r    <= align_nxt;
    n_r        <= n_nxt;
    initial_r  <= initial_nxt;
    mask_r     <= mask_nxt;
    first_r    <= first_nxt;
    off_r      <= off_nxt;
    cand_r     <= cand_nxt;
    wrapped_r  <= wrapped_nxt;
    runs_r     <= runs_nxt;
    rd_idx_r   <= rd_idx_nxt;
    left_r     <= left_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/afrf_ram.sv
// generic simple dual-port ram with registered read
module afrf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/afrf_checker.sv
// port-level checker for the aligned free run finder, bound to the top level
`include "aligned_free_run_finder_core_assert.svh"

module afrf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input afrf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input afrf_pkg::out_item_t out_data
);

  import afrf_pkg::*;

  // a result never overlaps a search in progress
  `AFRF_ASSERT_SAME(a_result_when_idle, out_valid, !busy)

  // a set transaction answers not found with zero runs examined in the next cycle
  `AFRF_ASSERT_NEXT(a_set_answer, start && !busy && (in_data.req_type == REQ_SET), out_valid && !out_data.found && (out_data.runs_examined == '0))

  // a found run took at least one candidate
  `AFRF_ASSERT_SAME(a_found_runs, out_valid && out_data.found, out_data.runs_examined != '0)

  // a miss reports start page zero
  `AFRF_ASSERT_SAME(a_miss_start, out_valid && !out_data.found, out_data.start_index == '0)

  // the block only goes busy for an accepted search
  `AFRF_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start) && ($past(in_data.req_type) == REQ_SEARCH))

endmodule

bind aligned_free_run_finder_core afrf_checker u_afrf_checker (.*);

>>> tb/aligned_free_run_finder_core_test.sv
// self-checking testbench of the aligned free run finder core: page updates and run searches
module aligned_free_run_finder_core_test;
  import afrf_pkg::*;

  // clock, reset and block ports
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_BASE_PAGE;
  logic [BASE_W-1:0] cfg_wdata = '0;

  // requests waiting to be driven and answers waiting to come back
  in_item_t  request_queue[$];
  out_item_t expected_answers[$];

  // the scoreboard's own copy of the block state and registers
  bit [MAX_PAGES-1:0] page_free_map = '0;  // all pages in use out of reset
  logic [PAGE_W-1:0]  next_fit_hint = '0;
  logic [BASE_W-1:0]  arena_base = '0;
  logic [CNT_W-1:0]   arena_size = CNT_W'(MAX_PAGES);

  // driver knobs and run statistics
  bit          steady_drive = 1'b0;
  int unsigned gap_left = 0;
  int unsigned mismatches = 0;
  int unsigned sets_done = 0;
  int unsigned searches_done = 0;
  int unsigned runs_found = 0;
  int unsigned settings_used = 1;

  aligned_free_run_finder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first page at or after off whose physical address meets the alignment
  function automatic longint unsigned aligned_at_or_after(longint unsigned off,
                                                          longint unsigned first,
                                                          longint unsigned mask);
    if (off < first) return first;
    return ((off - first + mask) & ~mask) + first;
  endfunction

  // applies one request to the scoreboard state and returns the answer the block owes
  function automatic out_item_t answer_for(in_item_t req);
    out_item_t       ans;
    longint unsigned len, aln, n, mask, first, hint0, cand, i;
    int unsigned     steps;
    bit              wrapped, hit_busy, done;
    ans = '0;
    if (req.req_type == REQ_SET) begin
      page_free_map[req.page_index] = req.page_free;
      return ans;
    end
    len = req.run_length;
    aln = req.align_exp;
    // zero length answers not found without touching the hint
    if (len == 0) return ans;
    if (aln < PAGE_SHIFT) aln = PAGE_SHIFT;
    n = (arena_size > MAX_PAGES) ? MAX_PAGES : arena_size;
    mask = (64'd1 << (aln - PAGE_SHIFT)) - 64'd1;
    // page offset that makes base + offset aligned
    first = (64'd0 - 64'(arena_base)) & mask;
    hint0 = next_fit_hint;
    cand = aligned_at_or_after(hint0, first, mask);
    steps = 0;
    wrapped = 1'b0;
    done = 1'b0;
    while (!done && (!wrapped || cand < hint0)) begin
      if (steps < RUNS_SAT) steps++;
      if (!(cand <= n && len <= n - cand)) begin
        // candidate overruns the arena: wrap once, give up on the second overrun
        if (wrapped) begin
          done = 1'b1;
        end else begin
          wrapped = 1'b1;
          cand = first;
        end
      end else begin
        // walk the candidate from its last page back to its first
        i = cand + len;
        hit_busy = 1'b0;
        while (i > cand && !hit_busy) begin
          i--;
          if (!page_free_map[i]) hit_busy = 1'b1;
        end
        if (!hit_busy) begin
          next_fit_hint = PAGE_W'((cand + len) % n);
          ans.found = 1'b1;
          ans.start_index = cand[PAGE_W-1:0];
          done = 1'b1;
        end else begin
          cand = aligned_at_or_after(i + 1, first, mask);
        end
      end
    end
    ans.runs_examined = steps[RUNS_W-1:0];
    return ans;
  endfunction

  // driver: holds each request until the block takes it, with random gaps
  always @(posedge clk) begin : drive_requests
    logic      next_start;
    in_item_t  next_item;
    out_item_t ans;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      next_start = start;
      next_item = in_data;
      if (start && !busy) begin
        // transaction taken at this edge
        ans = answer_for(in_data);
        expected_answers.push_back(ans);
        if (in_data.req_type == REQ_SET) sets_done++;
        else searches_done++;
        if (ans.found) runs_found++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          if (!steady_drive && $urandom_range(0, 4) == 0) begin
            // this cycle opens an idle burst instead of a request
            gap_left = $urandom_range(1, 10) - 1;
          end else begin
            next_item = request_queue.pop_front();
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
      in_data <= next_item;
    end
  end

  // monitor: every strobed result must match the oldest outstanding answer
  always @(posedge clk) begin : check_answers
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("result with no transaction outstanding: found %0d start %0d runs %0d",
               out_data.found, out_data.start_index, out_data.runs_examined);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          mismatches++;
        end
        if (out_data.start_index !== want.start_index) begin
          $error("start_index: expected %0d, got %0d", want.start_index, out_data.start_index);
          mismatches++;
        end
        if (out_data.runs_examined !== want.runs_examined) begin
          $error("runs_examined: expected %0d, got %0d",
                 want.runs_examined, out_data.runs_examined);
          mismatches++;
        end
      end
    end
  end

  function automatic void queue_set(logic [PAGE_W-1:0] page, logic free_bit);
    in_item_t r;
    r.req_type = REQ_SET;
    r.page_index = page;
    r.page_free = free_bit;
    // search fields are don't-care here, keep them moving anyway
    r.run_length = CNT_W'($urandom_range(0, 8191));
    r.align_exp = ALN_W'($urandom_range(0, 63));
    request_queue.push_back(r);
  endfunction

  function automatic void queue_search(int unsigned len, int unsigned aln);
    in_item_t r;
    r.req_type = REQ_SEARCH;
    r.page_index = PAGE_W'($urandom_range(0, 4095));
    r.page_free = 1'($urandom_range(0, 1));
    r.run_length = CNT_W'(len);
    r.align_exp = ALN_W'(aln);
    request_queue.push_back(r);
  endfunction

  // block is quiet: nothing queued, nothing presented, nothing outstanding
  task automatic wait_until_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || start || busy || expected_answers.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_arena_config(logic [BASE_W-1:0] base, logic [CNT_W-1:0] pages);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE_PAGE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_ARENA_PAGES;
    cfg_wdata <= BASE_W'(pages);
    @(posedge clk);
    cfg_we <= 1'b0;
    arena_base = base;
    arena_size = pages;
    settings_used++;
    @(negedge clk);
  endtask

  // random traffic: lone page updates, freed runs followed by a search for
  // them (sometimes with a page knocked out again), and free-form searches
  task automatic queue_mixed_traffic(int unsigned count, int unsigned span,
                                     int unsigned max_len, int unsigned max_big);
    int unsigned made, pick, run, aln, first_page, k;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 6) == 0) first_page = $urandom_range(0, 4095);
        else first_page = $urandom_range(0, span - 1);
        queue_set(PAGE_W'(first_page), $urandom_range(0, 9) < 6);
        made++;
      end else if (pick < 60) begin
        run = $urandom_range(1, max_len);
        first_page = $urandom_range(0, span - 1);
        for (k = 0; k < run; k++) queue_set(PAGE_W'(first_page + k), 1'b1);
        made += run;
        if ($urandom_range(0, 9) == 0) begin
          queue_set(PAGE_W'(first_page + $urandom_range(0, run - 1)), 1'b0);
          made++;
        end
        aln = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12);
        queue_search($urandom_range(1, run), aln);
        made++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) run = $urandom_range(1, max_len);
        else if (pick < 85) run = $urandom_range(1, max_big);
        else if (pick < 95) run = $urandom_range(0, 8191);
        else run = 0;
        pick = $urandom_range(0, 9);
        if (pick < 4) aln = $urandom_range(0, 12);
        else if (pick < 8) aln = $urandom_range(13, 16);
        else aln = $urandom_range(0, 63);
        queue_search(run, aln);
        made++;
      end
    end
  endtask

  task automatic run_phase(logic [BASE_W-1:0] base, logic [CNT_W-1:0] pages, int unsigned count,
                           int unsigned span, int unsigned max_len, int unsigned max_big);
    wait_until_idle();
    write_arena_config(base, pages);
    queue_mixed_traffic(count, span, max_len, max_big);
  endtask

  // stimulus
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings: base 0, full arena, every page in use
    queue_search(1, 12);        // nothing free: full sweep, then not found
    queue_set(12'd0, 1'b1);     // lowest page index
    queue_set(12'd4095, 1'b1);  // highest page index
    queue_set(12'd7, 1'b1);
    queue_set(12'd7, 1'b0);     // back to in use
    queue_search(0, 12);        // zero run length
    queue_search(1, 0);         // alignment below a page is raised to a page
    queue_search(1, 63);        // widest alignment: first candidate overruns, wraps
    queue_search(1, 12);        // finds the top page, hint wraps to zero
    queue_search(8191, 12);     // longest field value never fits
    queue_search(4096, 12);     // whole arena, mostly busy
    for (int p = 100; p < 104; p++) queue_set(PAGE_W'(p), 1'b1);
    queue_search(4, 14);
    queue_search(2, 13);
    queue_search(3, 12);
    queue_set(12'd4095, 1'b0);
    queue_search(1, 51);
    queue_search(2, 12);

    // base and arena sweep, extremes included; shrinking the arena below the
    // hint and the oversize and empty arenas show up along the way
    run_phase(BASE_W'({$urandom, $urandom}), 13'd64, 400, 64, 8, 64);
    run_phase({BASE_W{1'b1}}, 13'd1, 80, 4, 1, 1);
    run_phase(BASE_W'($urandom_range(1, 255)), 13'd4096, 90, 256, 2, 4);
    run_phase(BASE_W'({$urandom, $urandom}), 13'd0, 20, 16, 4, 8);
    run_phase('0, 13'd5000, 40, 256, 2, 4);
    run_phase(BASE_W'({$urandom, $urandom}), CNT_W'($urandom_range(100, 300)), 380, 300, 8,
              32);
    run_phase(BASE_W'(40'h1), 13'd2, 100, 2, 2, 2);

    // last stretch driven back to back
    wait_until_idle();
    steady_drive = 1'b1;
    write_arena_config(BASE_W'({$urandom, $urandom}), 13'd37);
    queue_mixed_traffic(320, 37, 8, 37);

    wait_until_idle();
    repeat (200) @(negedge clk);
    $display("covered %0d page updates and %0d searches (%0d runs found)",
             sets_done, searches_done, runs_found);
    $display("over %0d base/arena settings, %0d field mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #500_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/afrf_pkg.sv
hdl/afrf_ram.sv
hdl/aligned_free_run_finder_core.sv
hdl/afrf_checker.sv
tb/aligned_free_run_finder_core_test.sv
